// File: rtl/kmh_pkg.sv
// Package for the k-way merge heap accumulator: codes, types, constants.
// No dependencies.
package kmh_pkg;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned AW = 6;
  localparam int unsigned CW = 7;
  localparam logic [47:0] VMAX = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    FN_LOAD  = 2'd0,
    FN_START = 2'd1,
    FN_REFILL = 2'd2,
    FN_EXHAUST = 2'd3
  } func_t;

  // heap entry: key, value, source
  typedef struct packed {
    logic [47:0] key;
    logic [47:0] value;
    logic [5:0]  source;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_ROOT_RD,
    ST_ROOT_GOT,
    ST_LAST_RD,
    ST_DN_RD,
    ST_DN_CMP,
    ST_OUT
  } state_t;

  // memory port request
  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    entry_t        wdata;
    logic [AW-1:0] raddr;
  } mem_req_t;

endpackage

// File: rtl/kway_merge_heap_accumulate_core.sv
// K-way merge heap accumulator, top level.
// Channels: input words (func, src, in_word1, in_word2, in_value) with
// in_valid/in_ready; result words (rec_valid .. finished) with out_valid/
// out_ready. An input word yields zero or one result word.
// Records are held in a 64-entry binary min-heap in one RAM with registered
// reads and two read ports. A load sifts up, reading the parent and then
// comparing at each level. A start, refill or exhaust pushes (if any), reads
// the root, moves the last entry to the root and sifts down, reading both
// children together at each level. Items are handled one at a time.
// The result sits in an output register; the next input word is taken while
// it waits, but the block stalls before writing a new result until the
// receiver takes the old one.
// Reset (rst, synchronous) empties the heap and clears the held record; the
// RAM itself is not cleared, only entries below the count are ever used.
module kway_merge_heap_accumulate_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [5:0]  src,
  input  logic [23:0] in_word1,
  input  logic [23:0] in_word2,
  input  logic [47:0] in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        rec_valid,
  output logic [23:0] out_word1,
  output logic [23:0] out_word2,
  output logic [47:0] out_value,
  output logic [5:0]  want_source,
  output logic        want_valid,
  output logic        finished
);

  localparam int unsigned AW = kmh_pkg::AW;
  localparam int unsigned CW = kmh_pkg::CW;

  kmh_pkg::state_t state, state_next;
  kmh_pkg::mem_req_t req;
  logic [AW-1:0] raddr_b;
  kmh_pkg::entry_t rd_a, rd_b;

  logic [CW-1:0] count, count_next;
  logic [47:0]   held_key, held_key_next;
  logic [47:0]   held_value, held_value_next;
  logic [5:0]    last_src, last_src_next;
  logic          merging, merging_next;
  logic          pending, pending_next;

  // working registers of the sift
  kmh_pkg::entry_t cur, cur_next;   // entry being sifted
  logic [AW-1:0] pos, pos_next;
  logic [CW-1:0] n, n_next;         // size during sift down
  logic          refill_pop, refill_pop_next; // pop follows (refill or exhaust)

  // result staging
  logic          r_rec, r_rec_next, r_fin, r_fin_next, r_want, r_want_next;
  logic [47:0]   r_key, r_key_next, r_val, r_val_next;
  logic [5:0]    r_src, r_src_next;
  logic          ov, ov_next;

  kmh_ram u_ram (.clk(clk), .req(req), .raddr_b(raddr_b),
                 .rdata_a(rd_a), .rdata_b(rd_b));

  logic [AW-1:0] parent;
  logic [CW:0]   lc;
  logic [48:0]   sum;
  kmh_pkg::entry_t child;
  logic [AW-1:0] child_pos;

  assign parent = AW'((pos - AW'(1)) >> 1);
  assign lc = {1'b0, pos, 1'b1};
  assign sum = {1'b0, held_value} + {1'b0, rd_a.value};

  assign in_ready = (state == kmh_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kmh_pkg::ST_IDLE;
      count <= '0;
      held_key <= '0;
      held_value <= '0;
      last_src <= '0;
      merging <= 1'b0;
      pending <= 1'b0;
      ov <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      held_key <= held_key_next;
      held_value <= held_value_next;
      last_src <= last_src_next;
      merging <= merging_next;
      pending <= pending_next;
      ov <= ov_next;
    end
    cur <= cur_next;
    pos <= pos_next;
    n <= n_next;
    refill_pop <= refill_pop_next;
    r_rec <= r_rec_next;
    r_fin <= r_fin_next;
    r_want <= r_want_next;
    r_key <= r_key_next;
    r_val <= r_val_next;
    r_src <= r_src_next;
  end

  // sequencer: sift up, pop, sift down, emit
  always_comb begin
    state_next = state;
    count_next = count;
    held_key_next = held_key;
    held_value_next = held_value;
    last_src_next = last_src;
    merging_next = merging;
    pending_next = pending;
    ov_next = ov && !out_ready;
    cur_next = cur;
    pos_next = pos;
    n_next = n;
    refill_pop_next = refill_pop;
    r_rec_next = r_rec;
    r_fin_next = r_fin;
    r_want_next = r_want;
    r_key_next = r_key;
    r_val_next = r_val;
    r_src_next = r_src;
    req = '0;
    req.raddr = '0;
    raddr_b = '0;
    child = rd_a;
    child_pos = AW'(lc);
    unique case (state)
      kmh_pkg::ST_IDLE: begin
        if (in_valid) begin
          cur_next = '{key: {in_word1, in_word2}, value: in_value, source: src};
          r_rec_next = 1'b0;
          r_fin_next = 1'b0;
          r_want_next = 1'b0;
          r_key_next = '0;
          r_val_next = '0;
          r_src_next = '0;
          unique case (kmh_pkg::func_t'(func))
            kmh_pkg::FN_LOAD: begin
              if (!merging && count < CW'(kmh_pkg::DEPTH)) begin
                pos_next = AW'(count);
                count_next = count + CW'(1);
                refill_pop_next = 1'b0;
                state_next = kmh_pkg::ST_UP_RD;
              end
            end
            kmh_pkg::FN_START: begin
              if (!merging) begin
                if (count == '0) begin
                  r_fin_next = 1'b1;
                  state_next = kmh_pkg::ST_OUT;
                end else begin
                  merging_next = 1'b1;
                  refill_pop_next = 1'b0;
                  state_next = kmh_pkg::ST_ROOT_RD;
                end
              end
            end
            kmh_pkg::FN_REFILL: begin
              if (pending) begin
                pending_next = 1'b0;
                cur_next.source = last_src;
                refill_pop_next = 1'b1;
                if (count < CW'(kmh_pkg::DEPTH)) begin
                  pos_next = AW'(count);
                  count_next = count + CW'(1);
                  state_next = kmh_pkg::ST_UP_RD;
                end else begin
                  state_next = kmh_pkg::ST_ROOT_RD;
                end
              end
            end
            default: begin
              if (pending) begin
                pending_next = 1'b0;
                refill_pop_next = 1'b1;
                state_next = kmh_pkg::ST_ROOT_RD;
              end
            end
          endcase
        end
      end
      kmh_pkg::ST_UP_RD: begin
        // read parent of the hole
        req.raddr = parent;
        if (pos == '0) begin
          req.we = 1'b1;
          req.waddr = pos;
          req.wdata = cur;
          state_next = refill_pop ? kmh_pkg::ST_ROOT_RD : kmh_pkg::ST_IDLE;
        end else begin
          state_next = kmh_pkg::ST_UP_CMP;
        end
      end
      kmh_pkg::ST_UP_CMP: begin
        req.we = 1'b1;
        req.waddr = pos;
        if (rd_a.key > cur.key) begin
          req.wdata = rd_a;
          pos_next = parent;
          state_next = kmh_pkg::ST_UP_RD;
        end else begin
          req.wdata = cur;
          state_next = refill_pop ? kmh_pkg::ST_ROOT_RD : kmh_pkg::ST_IDLE;
        end
      end
      kmh_pkg::ST_ROOT_RD: begin
        req.raddr = '0;
        raddr_b = AW'(count - CW'(1));
        if (count == '0) begin
          // heap ran empty: emit held record with finished
          r_rec_next = 1'b1;
          r_fin_next = 1'b1;
          r_key_next = held_key;
          r_val_next = held_value;
          merging_next = 1'b0;
          state_next = kmh_pkg::ST_OUT;
        end else begin
          state_next = kmh_pkg::ST_ROOT_GOT;
        end
      end
      kmh_pkg::ST_ROOT_GOT: begin
        if (!refill_pop) begin
          held_key_next = rd_a.key;
          held_value_next = rd_a.value;
        end else if (rd_a.key == held_key) begin
          held_value_next = sum[48] ? kmh_pkg::VMAX : sum[47:0];
        end else begin
          r_rec_next = 1'b1;
          r_key_next = held_key;
          r_val_next = held_value;
          held_key_next = rd_a.key;
          held_value_next = rd_a.value;
        end
        last_src_next = rd_a.source;
        r_want_next = 1'b1;
        r_src_next = rd_a.source;
        pending_next = 1'b1;
        cur_next = rd_b;
        n_next = count - CW'(1);
        count_next = count - CW'(1);
        pos_next = '0;
        state_next = kmh_pkg::ST_DN_RD;
      end
      kmh_pkg::ST_DN_RD: begin
        req.raddr = AW'(lc);
        raddr_b = AW'(lc + (CW+1)'(1));
        if (lc >= {1'b0, n}) begin
          req.we = (n != '0);
          req.waddr = pos;
          req.wdata = cur;
          state_next = kmh_pkg::ST_OUT;
        end else begin
          state_next = kmh_pkg::ST_DN_CMP;
        end
      end
      kmh_pkg::ST_DN_CMP: begin
        if (lc + (CW+1)'(1) < {1'b0, n} && !(rd_a.key < rd_b.key)) begin
          child = rd_b;
          child_pos = AW'(lc + (CW+1)'(1));
        end
        req.we = 1'b1;
        req.waddr = pos;
        if (cur.key > child.key) begin
          req.wdata = child;
          pos_next = child_pos;
          state_next = kmh_pkg::ST_DN_RD;
        end else begin
          req.wdata = cur;
          state_next = kmh_pkg::ST_OUT;
        end
      end
      kmh_pkg::ST_OUT: begin
        if (!ov || out_ready) begin
          ov_next = 1'b1;
          state_next = kmh_pkg::ST_IDLE;
        end
      end
      default: state_next = kmh_pkg::ST_IDLE;
    endcase
  end

  // output register
  logic        o_rec, o_fin, o_want;
  logic [47:0] o_key, o_val;
  logic [5:0]  o_src;
  always_ff @(posedge clk) begin
    if (state == kmh_pkg::ST_OUT && (!ov || out_ready)) begin
      o_rec <= r_rec;
      o_fin <= r_fin;
      o_want <= r_want;
      o_key <= r_key;
      o_val <= r_val;
      o_src <= r_src;
    end
  end

  assign out_valid = ov;
  assign rec_valid = o_rec;
  assign out_word1 = o_key[47:24];
  assign out_word2 = o_key[23:0];
  assign out_value = o_val;
  assign want_source = o_src;
  assign want_valid = o_want;
  assign finished = o_fin;

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(kmh_pkg::DEPTH)) else $error("heap count overflow");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    ov && !out_ready |=> $stable(o_key) && $stable(o_val) && ov)
    else $error("result changed under stall");
  a_fin_stop: assert property (@(posedge clk) disable iff (rst)
    state == kmh_pkg::ST_ROOT_RD && count == '0 |=> !merging)
    else $error("merge not ended on empty heap");
  a_pend_merge: assert property (@(posedge clk) disable iff (rst)
    pending |-> merging) else $error("request outside merge");
`endif

endmodule

// File: rtl/kmh_ram.sv
// Heap storage: one synchronous RAM of entries, one write and two reads.
// Depends on kmh_pkg.
module kmh_ram (
  input  logic                     clk,
  input  kmh_pkg::mem_req_t        req,
  input  logic [kmh_pkg::AW-1:0]   raddr_b,
  output kmh_pkg::entry_t          rdata_a,
  output kmh_pkg::entry_t          rdata_b
);

  kmh_pkg::entry_t mem [kmh_pkg::DEPTH];

  // write port and registered reads
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata_a <= mem[req.raddr];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: tb/kmh_checker.sv
// Checker for the k-way merge heap accumulator: watches both channels, keeps
// its own heap model, predicts result words and compares. Depends on kmh_pkg.
`timescale 1ns / 100ps
module kmh_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  func,
  input  logic [5:0]  src,
  input  logic [23:0] in_word1,
  input  logic [23:0] in_word2,
  input  logic [47:0] in_value,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        rec_valid,
  input  logic [23:0] out_word1,
  input  logic [23:0] out_word2,
  input  logic [47:0] out_value,
  input  logic [5:0]  want_source,
  input  logic        want_valid,
  input  logic        finished,
  output int          errors,
  output int          pending_words,
  output int          records_seen,
  output int          finishes_seen
);

  typedef struct packed {
    logic        rec;
    logic [23:0] w1;
    logic [23:0] w2;
    logic [47:0] val;
    logic [5:0]  want;
    logic        wv;
    logic        fin;
  } res_t;

  res_t        merge_q[$];
  logic [47:0] hk[kmh_pkg::DEPTH];
  logic [47:0] hv[kmh_pkg::DEPTH];
  logic [5:0]  hs[kmh_pkg::DEPTH];
  int          hcnt;
  logic [47:0] held_k, held_v;
  logic [5:0]  last_src;
  bit          merging, awaiting;

  function automatic void swap_ent(int a, int b);
    logic [47:0] k, v;
    logic [5:0]  s;
    k = hk[a]; hk[a] = hk[b]; hk[b] = k;
    v = hv[a]; hv[a] = hv[b]; hv[b] = v;
    s = hs[a]; hs[a] = hs[b]; hs[b] = s;
  endfunction

  function automatic void heap_insert(logic [47:0] k, logic [47:0] v, logic [5:0] s);
    int j, p;
    if (hcnt >= kmh_pkg::DEPTH) return;
    j = hcnt;
    hk[j] = k; hv[j] = v; hs[j] = s;
    hcnt++;
    while (j > 0) begin
      p = (j - 1) / 2;
      if (hk[p] > hk[j]) begin
        swap_ent(p, j);
        j = p;
      end else break;
    end
  endfunction

  function automatic void heap_remove_root();
    int n, p, j, c;
    n = hcnt; p = 0;
    hk[0] = hk[n-1]; hv[0] = hv[n-1]; hs[0] = hs[n-1];
    while ((2 * p + 1) < n - 1) begin
      j = 2 * p + 1;
      if (j == n - 2) begin
        if (hk[p] > hk[j]) swap_ent(p, j);
        break;
      end
      // ties go to the right child
      c = (hk[j] < hk[j+1]) ? j : j + 1;
      if (hk[p] > hk[c]) begin
        swap_ent(p, c);
        p = c;
      end else break;
    end
    hcnt = n - 1;
  endfunction

  function automatic void emit_held(ref res_t r);
    r.rec = 1'b1;
    r.w1  = held_k[47:24];
    r.w2  = held_k[23:0];
    r.val = held_v;
  endfunction

  // model one accepted input word
  function automatic void predict_merge(logic [1:0] f, logic [5:0] s, logic [47:0] k,
                                        logic [47:0] v);
    res_t        r;
    logic [48:0] sum;
    r = '0;
    if (f == kmh_pkg::FN_LOAD) begin
      if (!merging) heap_insert(k, v, s);
      return;
    end
    if (f == kmh_pkg::FN_START) begin
      if (merging) return;
      if (hcnt == 0) begin
        r.fin = 1'b1;
        merge_q.push_back(r);
        return;
      end
      held_k = hk[0]; held_v = hv[0]; last_src = hs[0];
      heap_remove_root();
      merging = 1; awaiting = 1;
      r.want = last_src; r.wv = 1'b1;
      merge_q.push_back(r);
      return;
    end
    if (!awaiting) return;
    if (f == kmh_pkg::FN_REFILL) heap_insert(k, v, last_src);
    awaiting = 0;
    if (hcnt == 0) begin
      emit_held(r);
      r.fin = 1'b1;
      merging = 0;
      merge_q.push_back(r);
      return;
    end
    if (hk[0] == held_k) begin
      sum = {1'b0, held_v} + {1'b0, hv[0]};
      held_v = sum[48] ? kmh_pkg::VMAX : sum[47:0];
    end else begin
      emit_held(r);
      held_k = hk[0]; held_v = hv[0];
    end
    last_src = hs[0];
    heap_remove_root();
    awaiting = 1;
    r.want = last_src; r.wv = 1'b1;
    merge_q.push_back(r);
  endfunction

  always @(posedge clk) begin
    res_t e, a;
    if (rst) begin
      hcnt = 0; held_k = '0; held_v = '0; last_src = '0;
      merging = 0; awaiting = 0;
      merge_q.delete();
      errors = 0; records_seen = 0; finishes_seen = 0;
    end else begin
      if (out_valid && out_ready) begin
        a = '{rec_valid, out_word1, out_word2, out_value, want_source, want_valid,
              finished};
        if (merge_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result word %h", $time, a);
        end else begin
          e = merge_q.pop_front();
          if (a.rec) records_seen++;
          if (a.fin) finishes_seen++;
          if (a.rec !== e.rec) begin
            errors++;
            $display("%0t: rec_valid exp %0d got %0d", $time, e.rec, a.rec);
          end
          if (a.w1 !== e.w1) begin
            errors++;
            $display("%0t: out_word1 exp %h got %h", $time, e.w1, a.w1);
          end
          if (a.w2 !== e.w2) begin
            errors++;
            $display("%0t: out_word2 exp %h got %h", $time, e.w2, a.w2);
          end
          if (a.val !== e.val) begin
            errors++;
            $display("%0t: out_value exp %h got %h", $time, e.val, a.val);
          end
          if (a.want !== e.want) begin
            errors++;
            $display("%0t: want_source exp %0d got %0d", $time, e.want, a.want);
          end
          if (a.wv !== e.wv) begin
            errors++;
            $display("%0t: want_valid exp %0d got %0d", $time, e.wv, a.wv);
          end
          if (a.fin !== e.fin) begin
            errors++;
            $display("%0t: finished exp %0d got %0d", $time, e.fin, a.fin);
          end
        end
      end
      if (in_valid && in_ready)
        predict_merge(func, src, {in_word1, in_word2}, in_value);
    end
    pending_words = merge_q.size();
  end

endmodule

// File: tb/tb_top.sv
// Testbench top for kway_merge_heap_accumulate_core: drives merge sessions of
// sorted sources with random gaps and stalls. Depends on kmh_pkg, kmh_checker and the core.
`timescale 1ns / 100ps
module tb_top;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_ready;
  logic [1:0]  func = kmh_pkg::FN_LOAD;
  logic [5:0]  src = '0;
  logic [23:0] in_word1 = '0;
  logic [23:0] in_word2 = '0;
  logic [47:0] in_value = '0;
  logic        out_valid;
  logic        out_ready = 0;
  logic        rec_valid, want_valid, finished;
  logic [23:0] out_word1, out_word2;
  logic [47:0] out_value;
  logic [5:0]  want_source;
  int          errors, pending_words, records_seen, finishes_seen;
  int          words_sent;
  bit          stim_done;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  kway_merge_heap_accumulate_core uut (.*);

  kmh_checker chk (.*);

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // send one input word, with an optional gap first; valid stays up after the
  // accept so back-to-back words never drop it
  task automatic send_word(logic [1:0] f, logic [5:0] s, logic [23:0] w1, logic [23:0] w2,
                           logic [47:0] v, bit no_gap = 0);
    int g;
    g = no_gap ? 0 : gap_len();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1; func <= f; src <= s;
    in_word1 <= w1; in_word2 <= w2; in_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  // drop valid, let the checker see the last word, then wait for all results
  task automatic wait_results();
    in_valid <= 0;
    @(negedge clk);
    wait (pending_words == 0);
    @(posedge clk);
  endtask

  function automatic logic [47:0] rand_val();
    case ($urandom_range(0, 3))
      0: return 48'({$urandom, $urandom});
      1: return kmh_pkg::VMAX - $urandom_range(0, 3);
      2: return 48'(($urandom_range(0, 255)) << 16);
      default: return 48'($urandom_range(0, 1000));
    endcase
  endfunction

  // receiver stall
  initial begin
    int g;
    @(negedge rst);
    forever begin
      g = gap_len();
      if (($urandom_range(0, 9)) == 0) g = 0;
      out_ready <= (g == 0);
      repeat (g > 0 ? g : $urandom_range(1, 12)) @(posedge clk);
      out_ready <= 1;
      @(posedge clk);
    end
  end

  // one merge session; narrow key space gives duplicates across sources
  task automatic run_session(int nsrc, int per_src, int kspan);
    logic [47:0] cur[64];
    int          left[64];
    logic [47:0] k;
    int          s;
    for (int i = 0; i < nsrc; i++) begin
      cur[i] = {24'($urandom_range(0, kspan)), 24'($urandom_range(0, kspan))};
      left[i] = $urandom_range(0, per_src);
      send_word(kmh_pkg::FN_LOAD, 6'(i), cur[i][47:24], cur[i][23:0], rand_val());
    end
    send_word(kmh_pkg::FN_START, 6'($urandom), 24'($urandom), 24'($urandom), rand_val());
    // follow the request stream by waiting for each result word
    forever begin
      wait_results();
      if (!chk.merging) break;
      s = chk.last_src;
      if (left[s] > 0) begin
        left[s]--;
        k = cur[s] + 48'($urandom_range(0, 2)) * ($urandom_range(0, 1) ? 1 : 48'h100_0000);
        if (k < cur[s]) k = cur[s];
        cur[s] = k;
        send_word(kmh_pkg::FN_REFILL, 6'($urandom), k[47:24], k[23:0], rand_val());
      end else
        send_word(kmh_pkg::FN_EXHAUST, 6'($urandom), 24'($urandom), 24'($urandom),
                  rand_val());
      // stray ignored word now and then
      if (($urandom_range(0, 30)) == 0)
        send_word(kmh_pkg::FN_LOAD, 6'($urandom), 24'($urandom), 24'($urandom),
                  rand_val());
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: empty start, stray refill/exhaust, field extremes
    send_word(kmh_pkg::FN_START, 6'd0, 24'd0, 24'd0, 48'd0);
    send_word(kmh_pkg::FN_REFILL, 6'd63, 24'hFFFFFF, 24'hFFFFFF, kmh_pkg::VMAX);
    send_word(kmh_pkg::FN_EXHAUST, 6'd0, 24'd0, 24'd0, 48'd0);
    send_word(kmh_pkg::FN_LOAD, 6'd63, 24'hFFFFFF, 24'hFFFFFF, kmh_pkg::VMAX);
    send_word(kmh_pkg::FN_LOAD, 6'd0, 24'hFFFFFF, 24'hFFFFFF, kmh_pkg::VMAX);
    send_word(kmh_pkg::FN_LOAD, 6'd5, 24'd0, 24'd0, 48'd1);
    send_word(kmh_pkg::FN_START, 6'd0, 24'd0, 24'd0, 48'd0);
    send_word(kmh_pkg::FN_START, 6'd0, 24'd0, 24'd0, 48'd0);
    send_word(kmh_pkg::FN_LOAD, 6'd7, 24'd1, 24'd1, 48'd1);
    wait_results();
    send_word(kmh_pkg::FN_REFILL, 6'd0, 24'd0, 24'd0, 48'd2);
    wait_results();
    send_word(kmh_pkg::FN_EXHAUST, 6'd0, 24'd0, 24'd0, 48'd0);
    wait_results();
    send_word(kmh_pkg::FN_EXHAUST, 6'd0, 24'd0, 24'd0, 48'd0);
    wait_results();
    send_word(kmh_pkg::FN_EXHAUST, 6'd0, 24'd0, 24'd0, 48'd0);
    wait_results();
    // full heap, then one more load that is dropped
    for (int i = 0; i < 65; i++)
      send_word(kmh_pkg::FN_LOAD, 6'(i), 24'($urandom_range(0, 3)),
                24'($urandom_range(0, 3)), rand_val(), 1);
    send_word(kmh_pkg::FN_START, 6'd0, 24'd0, 24'd0, 48'd0);
    wait_results();
    while (chk.merging) begin
      send_word(kmh_pkg::FN_EXHAUST, 6'd0, 24'd0, 24'd0, 48'd0);
      wait_results();
    end
    // random sessions
    while (words_sent < 1250) begin
      case ($urandom_range(0, 3))
        0: run_session($urandom_range(1, 4), 6, 3);
        1: run_session($urandom_range(2, 16), 4, 20);
        2: run_session(64, 1, 2);
        default: run_session($urandom_range(1, 8), 10, 1000);
      endcase
    end
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    @(negedge clk);
    wait (pending_words == 0);
    repeat (60) @(posedge clk);
    $display("Sent %0d input words; saw %0d records and %0d finished flags.",
             words_sent, records_seen, finishes_seen);
    if (errors == 0)
      $display("** kway_merge_heap_accumulate_core: PASSED **");
    else
      $display("** kway_merge_heap_accumulate_core: FAILED **");
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout with %0d result words outstanding.", pending_words);
    $display("** kway_merge_heap_accumulate_core: FAILED **");
    $finish;
  end

endmodule

// File: sim.f
rtl/kmh_pkg.sv
rtl/kmh_ram.sv
rtl/kway_merge_heap_accumulate_core.sv
tb/kmh_checker.sv
tb/tb_top.sv
